// ----- hdl/rlpl_pkg.sv -----
// Shared types and constants for the longest-prefix route lookup core.
package rlpl_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 16;
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int TREE_LVL    = $clog2(TABLE_SLOTS);
    localparam int TREE_N      = 1 << TREE_LVL;
    localparam int LVL_A       = TREE_LVL / 2;
    localparam int LVL_B       = TREE_LVL - LVL_A;
    localparam int MID_N       = TREE_N >> LVL_A;

    // Field widths
    localparam int ADDR_W       = 32;
    localparam int ENTRY_SLOT_W = 4;
    localparam int ROUTE_SLOT_W = 4;
    localparam int IN_FIELDS_W  = ENTRY_SLOT_W + 3 * ADDR_W + 1;
    localparam int S_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int M_DATA_W     = 8;

    // Item kind carried on tuser
    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_LOOKUP = 1'b1
    } kind_t;

    // Table write request
    typedef struct packed {
        logic                    en;
        logic [ENTRY_SLOT_W-1:0] slot;
        logic [ADDR_W-1:0]       prefix;
        logic [ADDR_W-1:0]       mask;
        logic                    valid;
    } tbl_wr_t;

    // Candidate route: matching mask (zero when no match) and its slot
    typedef struct packed {
        logic [ADDR_W-1:0] mask;
        logic [IDX_W-1:0]  idx;
    } node_t;

endpackage

// ----- hdl/rlpl_table.sv -----
// Route table storage with parallel prefix compare against a lookup address.
module rlpl_table
    import rlpl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tbl_wr_t                wr,
    input  logic [ADDR_W-1:0]      lookup_address,
    output node_t                  cand [TABLE_SLOTS],
    output logic [TABLE_SLOTS-1:0] dflt
);

    logic [ADDR_W-1:0]      prefix_reg [TABLE_SLOTS];
    logic [ADDR_W-1:0]      mask_reg   [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [TABLE_SLOTS-1:0] valid_next;

    // Valid bits: write hits at most one slot, out-of-range slots match none
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (wr.en && (int'(wr.slot) == i))
            begin
                valid_next[i] = wr.valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Prefix and mask payload, stored even when the entry is marked invalid
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (wr.en && (int'(wr.slot) == i))
            begin
                prefix_reg[i] <= wr.prefix;
                mask_reg[i]   <= wr.mask;
            end
        end
    end

    // Per-slot match and default-route flags
    always_comb
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            cand[i].idx  = IDX_W'(i);
            cand[i].mask = '0;
            if (valid_reg[i] &&
                ((lookup_address & mask_reg[i]) == (prefix_reg[i] & mask_reg[i])))
            begin
                cand[i].mask = mask_reg[i];
            end
            dflt[i] = valid_reg[i] && (mask_reg[i] == '0);
        end
    end

endmodule

// ----- hdl/route_longest_prefix_lookup_core.sv -----
// A lookup result passes stage 1, stage 2, stage 3 and the output register before m_tvalid.
// Throughput: one item per cycle while m_tready does not stall the pipeline; a write
// updates the table at its transfer and yields no result. Lookups pass the
// compare stage and the two-stage registered max tree over the slot masks.
// Reset clears all table valid bits and pipeline valids; prefix and mask
// storage is undefined until written.
module route_longest_prefix_lookup_core
    import rlpl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // entry_slot, entry_prefix, entry_mask,
                                          // entry_valid, lookup_address, zero pad
    input  logic [0:0]          s_tuser,  // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // route_found, route_slot, used_default,
                                          // zero pad
);

    // Unpack input fields
    localparam int PFX_LSB  = ENTRY_SLOT_W;
    localparam int MSK_LSB  = PFX_LSB + ADDR_W;
    localparam int VLD_BIT  = MSK_LSB + ADDR_W;
    localparam int ADDR_LSB = VLD_BIT + 1;

    kind_t             in_kind;
    logic [ADDR_W-1:0] in_addr;
    logic              in_xfer;
    tbl_wr_t           wr;

    assign in_kind  = kind_t'(s_tuser[0]);
    assign in_addr  = s_tdata[ADDR_LSB +: ADDR_W];
    assign in_xfer  = s_tvalid && s_tready;

    assign wr.en     = in_xfer && (in_kind == KIND_WRITE);
    assign wr.slot   = s_tdata[0 +: ENTRY_SLOT_W];
    assign wr.prefix = s_tdata[PFX_LSB +: ADDR_W];
    assign wr.mask   = s_tdata[MSK_LSB +: ADDR_W];
    assign wr.valid  = s_tdata[VLD_BIT];

    // Table and parallel compare
    node_t                  cand [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] dflt;

    rlpl_table u_table (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr             (wr),
        .lookup_address (in_addr),
        .cand           (cand),
        .dflt           (dflt)
    );

    // Larger mask wins, lower slot wins ties
    function automatic node_t pick(input node_t lo, input node_t hi);
        pick = (hi.mask > lo.mask) ? hi : lo;
    endfunction

    // Pipeline registers and stage enables
    logic                   v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic                   v1_next, v2_next, v3_next, out_valid_next;
    logic                   en1, en2, en3, en_out;
    node_t                  leaf1_reg [TREE_N];
    node_t                  leaf1_next [TREE_N];
    logic [TABLE_SLOTS-1:0] dflt1_reg, dflt2_reg;
    node_t                  mid2_reg [MID_N];
    node_t                  mid2_next [MID_N];
    node_t                  best3_reg, best3_next;
    logic [TABLE_SLOTS-1:0] dflt3_reg;
    logic                   found_reg, found_next;
    logic [ROUTE_SLOT_W-1:0] slot_reg, slot_next;
    logic                   used_dflt_reg, used_dflt_next;

    assign en_out   = !out_valid_reg || m_tready;
    assign en3      = !v3_reg || en_out;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // Stage 1: capture padded candidate leaves
    always_comb
    begin
        for (int j = 0; j < TREE_N; j++)
        begin
            leaf1_next[j] = '0;
            if (j < TABLE_SLOTS)
            begin
                leaf1_next[j] = cand[j];
            end
        end
    end

    // Stage 2: first levels of the max tree
    always_comb
    begin
        node_t work [TREE_N];
        work = leaf1_reg;
        for (int l = 0; l < LVL_A; l++)
        begin
            for (int j = 0; j < (TREE_N >> (l + 1)); j++)
            begin
                work[j] = pick(work[2*j], work[2*j+1]);
            end
        end
        for (int j = 0; j < MID_N; j++)
        begin
            mid2_next[j] = work[j];
        end
    end

    // Stage 3: remaining levels of the max tree
    always_comb
    begin
        node_t work [MID_N];
        work = mid2_reg;
        for (int l = 0; l < LVL_B; l++)
        begin
            for (int j = 0; j < (MID_N >> (l + 1)); j++)
            begin
                work[j] = pick(work[2*j], work[2*j+1]);
            end
        end
        best3_next = work[0];
    end

    // Output stage: resolve hit versus lowest default route
    always_comb
    begin
        logic             hit;
        logic             any_dflt;
        logic [IDX_W-1:0] dflt_idx;
        hit      = (best3_reg.mask != '0);
        any_dflt = |dflt3_reg;
        dflt_idx = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (dflt3_reg[i])
            begin
                dflt_idx = IDX_W'(i);
            end
        end
        found_next     = hit || any_dflt;
        used_dflt_next = !hit && any_dflt;
        if (hit)
        begin
            slot_next = ROUTE_SLOT_W'(best3_reg.idx);
        end
        else if (any_dflt)
        begin
            slot_next = ROUTE_SLOT_W'(dflt_idx);
        end
        else
        begin
            slot_next = '0;
        end
    end

    // Valid bits move with the data
    always_comb
    begin
        v1_next        = en1    ? (in_xfer && (in_kind == KIND_LOOKUP)) : v1_reg;
        v2_next        = en2    ? v1_reg : v2_reg;
        v3_next        = en3    ? v2_reg : v3_reg;
        out_valid_next = en_out ? v3_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, loaded only when their stage advances
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            leaf1_reg <= leaf1_next;
            dflt1_reg <= dflt;
        end
        if (en2)
        begin
            mid2_reg  <= mid2_next;
            dflt2_reg <= dflt1_reg;
        end
        if (en3)
        begin
            best3_reg <= best3_next;
            dflt3_reg <= dflt2_reg;
        end
        if (en_out)
        begin
            found_reg     <= found_next;
            slot_reg      <= slot_next;
            used_dflt_reg <= used_dflt_next;
        end
    end

    // Result port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - ROUTE_SLOT_W - 2){1'b0}},
                       used_dflt_reg, slot_reg, found_reg};

`ifndef SYNTH
    // Back-pressure only when every stage holds an item
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && out_valid_reg))
        else $error("input stalled with a bubble in the pipeline");

    // A lookup transfer always enters stage 1
    a_lookup_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[0] == KIND_LOOKUP)) |=> v1_reg)
        else $error("accepted lookup lost at stage 1");

    // A write transfer never starts a result
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[0] == KIND_WRITE)) |=> !v1_reg)
        else $error("write transfer produced a pipeline item");

    // Default flag implies a found route
    a_default_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!used_dflt_reg || found_reg))
        else $error("default route flagged without a found route");
`endif

endmodule

// ----- test/route_longest_prefix_lookup_core_tb.sv -----
// Self-checking testbench for the longest-prefix route lookup core.
`timescale 1ns / 1ps

module route_longest_prefix_lookup_core_tb;
    import rlpl_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 50;
    localparam int TAIL_CYCLES = 8;
    localparam int REPORT_MAX  = 10;

    // One input transfer, unpacked
    typedef struct packed {
        kind_t                   kind;
        logic [ENTRY_SLOT_W-1:0] slot;
        logic [ADDR_W-1:0]       prefix;
        logic [ADDR_W-1:0]       mask;
        logic                    valid;
        logic [ADDR_W-1:0]       address;
    } route_item_t;

    // One lookup result, unpacked
    typedef struct packed {
        logic                    found;
        logic [ROUTE_SLOT_W-1:0] slot;
        logic                    used_default;
    } route_result_t;

    // Route table copy, expected lookup results and mismatch bookkeeping
    class route_scoreboard;
        logic [ADDR_W-1:0] tbl_prefix [TABLE_SLOTS];
        logic [ADDR_W-1:0] tbl_mask [TABLE_SLOTS];
        bit                tbl_valid [TABLE_SLOTS];
        route_result_t     expected_routes [$];
        int                mismatches;

        function new();
            foreach (tbl_valid[i])
            begin
                tbl_valid[i]  = 1'b0;
                tbl_prefix[i] = '0;
                tbl_mask[i]   = '0;
            end
            mismatches = 0;
        endfunction

        // Numerically largest mask wins, lowest slot on a tie; else lowest zero-mask slot
        function route_result_t lookup_route(logic [ADDR_W-1:0] address);
            route_result_t     r;
            logic [ADDR_W-1:0] best_mask;
            r         = '0;
            best_mask = '0;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (tbl_valid[i] && ((address ^ tbl_prefix[i]) & tbl_mask[i]) == '0
                    && tbl_mask[i] > best_mask)
                begin
                    best_mask = tbl_mask[i];
                    r.found   = 1'b1;
                    r.slot    = ROUTE_SLOT_W'(i);
                end
            end
            if (!r.found)
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (tbl_valid[i] && tbl_mask[i] == '0)
                    begin
                        r.found        = 1'b1;
                        r.slot         = ROUTE_SLOT_W'(i);
                        r.used_default = 1'b1;
                        break;
                    end
                end
            end
            return r;
        endfunction

        // Accepted input: writes update the table, lookups queue a result
        function void note_item(route_item_t it);
            if (it.kind == KIND_WRITE)
            begin
                if (int'(it.slot) < TABLE_SLOTS)
                begin
                    tbl_prefix[it.slot] = it.prefix;
                    tbl_mask[it.slot]   = it.mask;
                    tbl_valid[it.slot]  = it.valid;
                end
            end
            else
                expected_routes.push_back(lookup_route(it.address));
        endfunction

        // Accepted result against the oldest expectation
        function void check_result(logic [M_DATA_W-1:0] data);
            route_result_t got;
            route_result_t want;
            got.found        = data[0];
            got.slot         = data[ROUTE_SLOT_W:1];
            got.used_default = data[ROUTE_SLOT_W+1];
            if (expected_routes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result found=%0b slot=%0d default=%0b",
                             $realtime, got.found, got.slot, got.used_default);
                return;
            end
            want = expected_routes.pop_front();
            if (got.found !== want.found || got.slot !== want.slot
                || got.used_default !== want.used_default)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: mismatch exp f=%0b s=%0d d=%0b got f=%0b s=%0d d=%0b",
                             $realtime, want.found, want.slot, want.used_default,
                             got.found, got.slot, got.used_default);
            end
        endfunction

        function int pending();
            return expected_routes.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // entry_slot, entry_prefix, entry_mask,
                                    // entry_valid, lookup_address, zero pad
    logic [0:0]          s_tuser;   // kind
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // route_found, route_slot, used_default,
                                    // zero pad

    route_scoreboard sb;
    int              sender_idle_pct;
    int              sink_idle_pct;
    int              hold_requests;
    int unsigned     cycle_count;

    // Prefix pool so random routes overlap and nest
    logic [ADDR_W-1:0] prefix_pool [4] = '{32'h0A00_0000, 32'hC0A8_0000,
                                          32'hAC10_0000, 32'hFFFF_0000};

    route_longest_prefix_lookup_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // Result checking
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Receiver: random stalls plus requested long hold-offs
    initial
    begin : sink_proc
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic route_item_t write_item(logic [ENTRY_SLOT_W-1:0] slot,
                                               logic [ADDR_W-1:0] prefix,
                                               logic [ADDR_W-1:0] mask, logic valid);
        route_item_t it;
        it        = '0;
        it.kind   = KIND_WRITE;
        it.slot   = slot;
        it.prefix = prefix;
        it.mask   = mask;
        it.valid  = valid;
        return it;
    endfunction

    function automatic route_item_t lookup_item(logic [ADDR_W-1:0] address);
        route_item_t it;
        it         = '0;
        it.kind    = KIND_LOOKUP;
        it.address = address;
        return it;
    endfunction

    // Random item; most lookups aim inside a live route
    function automatic route_item_t random_item();
        route_item_t it;
        int          live [$];
        int          pick;
        int          len;
        it.kind    = ($urandom_range(0, 99) < 30) ? KIND_WRITE : KIND_LOOKUP;
        it.slot    = ENTRY_SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
        it.valid   = ($urandom_range(0, 99) < 85);
        it.address = $urandom;
        if ($urandom_range(0, 1))
            it.prefix = prefix_pool[$urandom_range(0, 3)] | ($urandom & 32'h0000_FFFF);
        else
            it.prefix = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            it.mask = '0;
        else if (pick < 75)
        begin
            len     = $urandom_range(1, 32);
            it.mask = 32'hFFFF_FFFF << (32 - len);
        end
        else
            it.mask = $urandom;
        if (it.kind == KIND_LOOKUP && $urandom_range(0, 99) < 65)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (sb.tbl_valid[i])
                    live.push_back(i);
            if (live.size() != 0)
            begin
                pick       = live[$urandom_range(0, live.size() - 1)];
                it.address = (sb.tbl_prefix[pick] & sb.tbl_mask[pick])
                             | ($urandom & ~sb.tbl_mask[pick]);
            end
        end
        return it;
    endfunction

    // Offer one item and hold it until the transfer; returns at a falling edge
    task automatic send_route_item(route_item_t it);
        // each cycle the sender idles with the given chance
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= S_DATA_W'({it.address, it.valid, it.mask, it.prefix, it.slot});
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(it);
        @(negedge clk);
    endtask

    // Stop offering and wait until every expected result has arrived
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic run_random(int count, int send_pct, int sink_pct, int hold_at);
        sender_idle_pct = send_pct;
        sink_idle_pct   = sink_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
                hold_requests++;
            send_route_item(random_item());
        end
    endtask

    // Stimulus
    initial
    begin
        sb              = new();
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        hold_requests   = 0;
        sender_idle_pct = 27;
        sink_idle_pct   = 73;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty table, extremes, nesting, ties, defaults, removal
        send_route_item(lookup_item(32'h0000_0000));
        send_route_item(lookup_item(32'hFFFF_FFFF));
        send_route_item(write_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_route_item(lookup_item(32'hFFFF_FFFF));
        send_route_item(lookup_item(32'hFFFF_FFFE));
        // prefix bits below the mask must be ignored
        send_route_item(write_item(4'd7, 32'h0A00_00FF, 32'hFF00_0000, 1'b1));
        send_route_item(lookup_item(32'h0A12_3456));
        send_route_item(write_item(4'd9, 32'h0A12_0000, 32'hFFFF_0000, 1'b1));
        send_route_item(lookup_item(32'h0A12_3456));
        // equal masks: lower slot wins
        send_route_item(write_item(4'd4, 32'h0A12_FFFF, 32'hFFFF_0000, 1'b1));
        send_route_item(lookup_item(32'h0A12_ABCD));
        // two default routes, lowest one taken
        send_route_item(write_item(4'd12, 32'hDEAD_BEEF, 32'h0000_0000, 1'b1));
        send_route_item(write_item(4'd3, 32'h0000_0000, 32'h0000_0000, 1'b1));
        send_route_item(lookup_item(32'hC0A8_0001));
        send_route_item(lookup_item(32'h0A00_0001));
        // invalid write takes a slot out of the table
        send_route_item(write_item(4'd3, 32'h1234_5678, 32'h0000_0000, 1'b0));
        send_route_item(lookup_item(32'hC0A8_0001));
        // non-contiguous masks compare as plain numbers
        send_route_item(write_item(4'd0, 32'h8000_0000, 32'h8000_0001, 1'b1));
        send_route_item(lookup_item(32'h8000_0001));
        send_route_item(write_item(4'd1, 32'h0000_0001, 32'h0000_0001, 1'b1));
        send_route_item(lookup_item(32'h0000_0003));
        send_route_item(write_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_route_item(lookup_item(32'hFFFF_FFFF));
        send_route_item(lookup_item(32'h0000_0000));

        // Random phases: slow receiver, slow sender, then full rate
        run_random(180, 27, 73, 60);
        wait_results_drained();
        run_random(180, 73, 27, -1);
        wait_results_drained();
        run_random(190, 0, 0, 90);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
